[design/vsbj_pkg.sv]
// ----------------------------------------------------------------------------
// vsbj_pkg
// Shared types and constants of the vertical seam blend joiner.
// ----------------------------------------------------------------------------
package vsbj_pkg;

	localparam int LINE_W        = 12;
	localparam int CH_W          = 8;
	localparam int WGT_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int QUEUE_DEPTH   = 4;
	localparam int MAX_LINES_DEF = 4096;

	localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROWS  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ROWS = 2'd3;

	localparam logic [LINE_W-1:0] OUT_ROWS_RST    = 12'd768;
	localparam logic [LINE_W-1:0] OUT_COLS_RST    = 12'd1024;
	localparam logic [LINE_W-1:0] FIRST_ROWS_RST  = 12'd392;
	localparam logic [LINE_W-1:0] SECOND_ROWS_RST = 12'd392;

	// channel order within a pixel: [2] red, [1] green, [0] blue
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef enum logic [1:0] {
		RGN_UPPER = 2'd0,
		RGN_BLEND = 2'd1,
		RGN_LOWER = 2'd2,
		RGN_BLACK = 2'd3
	} region_t;

	typedef logic [2:0][CH_W-1:0] pix_t;

	typedef struct packed {
		pix_t              upper;
		pix_t              lower;
		logic [LINE_W-1:0] row;
		logic [LINE_W-1:0] row_off;
		region_t           region;
		logic              eol;
		logic              eof;
	} item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

[design/vsbj_front.sv]
// ----------------------------------------------------------------------------
// vsbj_front
// Configuration registers, raster counters and per-pixel region classification.
// ----------------------------------------------------------------------------
module vsbj_front #(
	parameter int MAX_LINES = vsbj_pkg::MAX_LINES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vsbj_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vsbj_pkg::LINE_W-1:0]    cfg_data,
	input  logic                           accept,
	input  vsbj_pkg::pix_t                 upper,
	input  vsbj_pkg::pix_t                 lower,
	output vsbj_pkg::item_t                item,
	output logic [vsbj_pkg::LINE_W-1:0]    divisor
);

	localparam int LW      = vsbj_pkg::LINE_W;
	localparam int LimRows = MAX_LINES - 1;

	logic [LW-1:0] out_rows_q, out_cols_q, first_rows_q, second_rows_q;
	logic [LW-1:0] row_q, col_q;
	logic [LW-1:0] orow, frow, srow, y, lim, blend_end, span;
	logic          eol, eof;
	vsbj_pkg::region_t region;

	function automatic logic [LW-1:0] clamp_rows(input logic [LW-1:0] v);
		return (int'(v) > LimRows) ? LW'(LimRows) : v;
	endfunction

	assign orow      = clamp_rows(out_rows_q);
	assign frow      = clamp_rows(first_rows_q);
	assign srow      = clamp_rows(second_rows_q);
	assign y         = (orow > srow) ? orow - srow : '0;
	assign lim       = (orow < frow) ? orow : frow;
	assign blend_end = (lim > y) ? lim : y;
	assign span      = blend_end - y;
	assign divisor   = frow - y;

	always_comb begin
		if (row_q >= orow) begin
			region = vsbj_pkg::RGN_BLACK;
		end else if (row_q < y) begin
			region = vsbj_pkg::RGN_UPPER;
		end else if (row_q < blend_end) begin
			region = vsbj_pkg::RGN_BLEND;
		end else if (span < srow) begin
			// y + srow is at least orow here, so row_q < orow covers it
			region = vsbj_pkg::RGN_LOWER;
		end else if (blend_end < frow) begin
			region = (row_q < frow) ? vsbj_pkg::RGN_UPPER : vsbj_pkg::RGN_BLACK;
		end else begin
			region = vsbj_pkg::RGN_BLACK;
		end
	end

	assign eol = ({1'b0, col_q} + 1'b1) >= {1'b0, out_cols_q};
	assign eof = eol && (({1'b0, row_q} + 1'b1) >= {1'b0, orow});

	always_comb begin
		item.upper   = upper;
		item.lower   = lower;
		item.row     = row_q;
		item.row_off = row_q - y;
		item.region  = region;
		item.eol     = eol;
		item.eof     = eof;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_rows_q    <= vsbj_pkg::OUT_ROWS_RST;
			out_cols_q    <= vsbj_pkg::OUT_COLS_RST;
			first_rows_q  <= vsbj_pkg::FIRST_ROWS_RST;
			second_rows_q <= vsbj_pkg::SECOND_ROWS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				vsbj_pkg::CFG_OUT_ROWS:    out_rows_q    <= cfg_data;
				vsbj_pkg::CFG_OUT_COLS:    out_cols_q    <= cfg_data;
				vsbj_pkg::CFG_FIRST_ROWS:  first_rows_q  <= cfg_data;
				vsbj_pkg::CFG_SECOND_ROWS: second_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (eol) begin
				col_q <= '0;
				row_q <= eof ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

[design/vsbj_queue.sv]
// ----------------------------------------------------------------------------
// vsbj_queue
// Short FIFO of classified pixels between the front and the back.
// ----------------------------------------------------------------------------
module vsbj_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vsbj_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output vsbj_pkg::item_t head,
	output logic            head_valid
);

	localparam int Depth = vsbj_pkg::QUEUE_DEPTH;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);

	vsbj_pkg::item_t mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	assign full       = count_q == CntW'(Depth);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/vsbj_div.sv]
// ----------------------------------------------------------------------------
// vsbj_div
// Restoring divider for the row weight, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vsbj_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [vsbj_pkg::LINE_W-1:0]  numer,
	input  logic [vsbj_pkg::LINE_W-1:0]  divisor,
	output vsbj_pkg::div_stat_t          stat,
	output logic [vsbj_pkg::WGT_W-1:0]   quotient
);

	localparam int LW   = vsbj_pkg::LINE_W;
	localparam int WW   = vsbj_pkg::WGT_W;
	localparam int CntW = $clog2(WW + 1);

	logic [LW-1:0]   rem_q;
	logic [WW-1:0]   quo_q;
	logic [CntW-1:0] cnt_q;
	logic            done_q;
	logic [LW:0]     shifted, trial;
	logic            ge;

	// remainder stays below divisor, so numerator < divisor on entry
	assign shifted = {rem_q, 1'b0};
	assign ge      = shifted >= {1'b0, divisor};
	assign trial   = shifted - {1'b0, divisor};

	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;
	assign quotient  = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= numer;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? trial[LW-1:0] : shifted[LW-1:0];
			quo_q <= {quo_q[WW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cnt_q == CntW'(1);
			if (start) begin
				cnt_q <= CntW'(WW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[design/vsbj_back.sv]
// ----------------------------------------------------------------------------
// vsbj_back
// Weight cache, divider control and the blend pipeline up to the output.
// ----------------------------------------------------------------------------
module vsbj_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  vsbj_pkg::item_t             head,
	input  logic                        head_valid,
	output logic                        pop,
	output logic                        div_start,
	output logic [vsbj_pkg::LINE_W-1:0] div_numer,
	input  vsbj_pkg::div_stat_t         div_stat,
	input  logic [vsbj_pkg::WGT_W-1:0]  div_quotient,
	input  logic                        out_ready,
	output logic                        out_valid,
	output vsbj_pkg::pix_t              res,
	output vsbj_pkg::region_t           res_region,
	output logic                        res_eol,
	output logic                        res_eof
);

	localparam int LW    = vsbj_pkg::LINE_W;
	localparam int WW    = vsbj_pkg::WGT_W;
	localparam int CW    = vsbj_pkg::CH_W;
	localparam int ProdW = CW + 1 + WW + 1;

	logic          wvalid_q;
	logic [LW-1:0] wrow_q;
	logic [WW-1:0] wgt_q;
	logic          head_blend, wt_hit, adv;

	logic                     valid_s1, valid_s2, valid_s3;
	vsbj_pkg::pix_t           upper_s1, upper_s2, lower_s1, lower_s2;
	logic signed [CW:0]       diff_s1 [3];
	logic [WW-1:0]            wgt_s1;
	vsbj_pkg::region_t        region_s1, region_s2, region_s3;
	logic                     eol_s1, eol_s2, eol_s3, eof_s1, eof_s2, eof_s3;
	logic signed [ProdW-1:0]  prod_s2 [3];
	vsbj_pkg::pix_t           res_s3, res_d;

	assign head_blend = head_valid && (head.region == vsbj_pkg::RGN_BLEND);
	assign wt_hit     = wvalid_q && (wrow_q == head.row);
	assign adv        = !valid_s3 || out_ready;
	assign pop        = head_valid && adv && (!head_blend || wt_hit);
	assign div_start  = head_blend && !wt_hit && !div_stat.busy && !div_stat.done;
	assign div_numer  = head.row_off;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= 1'b0;
		end else if (cfg_we) begin
			wvalid_q <= 1'b0;
		end else if (div_stat.done) begin
			wvalid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_stat.done) begin
			wrow_q <= head.row;
			wgt_q  <= div_quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			case (region_s2)
				vsbj_pkg::RGN_UPPER: res_d[k] = upper_s2[k];
				vsbj_pkg::RGN_BLEND: res_d[k] = upper_s2[k] + prod_s2[k][WW+CW-1:WW];
				vsbj_pkg::RGN_LOWER: res_d[k] = lower_s2[k];
				default:             res_d[k] = '0;
			endcase
		end
	end

	// p1 + floor((p2 - p1) * a / 2^16); the true result is 0..255
	always_ff @(posedge clk) begin
		if (adv) begin
			upper_s1  <= head.upper;
			lower_s1  <= head.lower;
			wgt_s1    <= (head.region == vsbj_pkg::RGN_BLEND) ? wgt_q : '0;
			region_s1 <= head.region;
			eol_s1    <= head.eol;
			eof_s1    <= head.eof;
			for (int k = 0; k < 3; k++) begin
				diff_s1[k] <= $signed({1'b0, head.lower[k]}) - $signed({1'b0, head.upper[k]});
				prod_s2[k] <= diff_s1[k] * $signed({1'b0, wgt_s1});
			end
			upper_s2  <= upper_s1;
			lower_s2  <= lower_s1;
			region_s2 <= region_s1;
			eol_s2    <= eol_s1;
			eof_s2    <= eof_s1;
			res_s3    <= res_d;
			region_s3 <= region_s2;
			eol_s3    <= eol_s2;
			eof_s3    <= eof_s2;
		end
	end

	assign out_valid  = valid_s3;
	assign res        = res_s3;
	assign res_region = region_s3;
	assign res_eol    = eol_s3;
	assign res_eof    = eof_s3;

endmodule

[design/vertical_seam_blend_joiner.sv]
// ----------------------------------------------------------------------------
// vertical_seam_blend_joiner
// Joins two vertically stacked RGB images into one frame with a feathered seam.
// ----------------------------------------------------------------------------
// While the output is not stalled, one pixel per cycle is taken and delivered
// in copy and black rows. In the overlap rows the first pixel of each row
// waits for its Q0.16 weight from a 16-step divider, once per row; unstalled,
// the rest of the row runs at one pixel per cycle from the cached weight. A
// pixel leaving the 4-entry queue passes through s1 and s2 into register s3.
module vertical_seam_blend_joiner #(
	parameter int MAX_LINES = vsbj_pkg::MAX_LINES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [vsbj_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vsbj_pkg::LINE_W-1:0]    cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     first_red,
	input  logic [7:0]                     first_green,
	input  logic [7:0]                     first_blue,
	input  logic [7:0]                     second_red,
	input  logic [7:0]                     second_green,
	input  logic [7:0]                     second_blue,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_red,
	output logic [7:0]                     out_green,
	output logic [7:0]                     out_blue,
	output logic [1:0]                     region,
	output logic                           end_of_line,
	output logic                           end_of_frame
);

	vsbj_pkg::pix_t      upper, lower, res;
	vsbj_pkg::item_t     front_item, head;
	vsbj_pkg::div_stat_t div_stat;
	vsbj_pkg::region_t   res_region;
	logic [vsbj_pkg::LINE_W-1:0] divisor, div_numer;
	logic [vsbj_pkg::WGT_W-1:0]  div_quotient;
	logic accept, full, pop, head_valid, div_start;

	assign upper  = {first_red, first_green, first_blue};
	assign lower  = {second_red, second_green, second_blue};
	assign in_ready = !full;
	assign accept = in_valid && in_ready;

	vsbj_front #(.MAX_LINES(MAX_LINES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.upper     (upper),
		.lower     (lower),
		.item      (front_item),
		.divisor   (divisor)
	);

	vsbj_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_item  (front_item),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	vsbj_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.numer    (div_numer),
		.divisor  (divisor),
		.stat     (div_stat),
		.quotient (div_quotient)
	);

	vsbj_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.div_start    (div_start),
		.div_numer    (div_numer),
		.div_stat     (div_stat),
		.div_quotient (div_quotient),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.res          (res),
		.res_region   (res_region),
		.res_eol      (end_of_line),
		.res_eof      (end_of_frame)
	);

	assign out_red   = res[vsbj_pkg::CH_RED];
	assign out_green = res[vsbj_pkg::CH_GREEN];
	assign out_blue  = res[vsbj_pkg::CH_BLUE];
	assign region    = res_region;

endmodule

[design/vsbj_checker.sv]
// ----------------------------------------------------------------------------
// vsbj_checker
// Port-level checks of the joiner output stream, bound to the top level.
// ----------------------------------------------------------------------------
module vsbj_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_we,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [1:0] region,
	input logic       end_of_line,
	input logic       end_of_frame
);

	a_black_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (region == vsbj_pkg::RGN_BLACK)
		|-> (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0))
		else $error("black fill transaction carries colour");

	a_eof_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_frame |-> end_of_line)
		else $error("end of frame without end of line");

	a_frame_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && end_of_frame && !cfg_we
		##1 out_valid && !$past(cfg_we) && (region == vsbj_pkg::RGN_UPPER)
		|-> !end_of_frame || end_of_line)
		else $error("frame boundary inconsistent");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready
		|=> out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)
			&& $stable(region) && $stable(end_of_line) && $stable(end_of_frame))
		else $error("stalled output transaction changed");

endmodule

bind vertical_seam_blend_joiner vsbj_checker u_vsbj_checker (.*);

[verif/vertical_seam_blend_joiner_test.sv]
// ----------------------------------------------------------------------------
// vertical_seam_blend_joiner_test
// Self-checking bench for the vertical seam blend joiner.
// ----------------------------------------------------------------------------
// Pixels go in through a valid/ready sender with random pauses. A local model
// of the row and column counters predicts each joined pixel: copy, feathered
// blend, lower copy or black fill, with line and frame markers. The results
// are checked in order. Directed cases cover zero sizes, an upper image
// shorter than the offset, frames shrunk mid-way and the register extremes.
// A long output stall follows, then randomised frame settings.
// ----------------------------------------------------------------------------
module vertical_seam_blend_joiner_test;

	localparam int          CLK_PERIOD  = 12;
	localparam int          SETTLE      = 32;
	localparam int          ITEM_TARGET = 1950;
	localparam int          HOLD_CYCLES = 300;
	localparam int          LW          = vsbj_pkg::LINE_W;
	localparam int unsigned LINE_LIMIT  = vsbj_pkg::MAX_LINES_DEF - 1;
	localparam int unsigned LINE_MASK   = (1 << LW) - 1;

	typedef struct packed {
		vsbj_pkg::pix_t    rgb;
		vsbj_pkg::region_t rgn;
		logic              eol;
		logic              eof;
	} joined_px_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic [vsbj_pkg::CFG_IDX_W-1:0] cfg_index = vsbj_pkg::CFG_OUT_ROWS;
	logic [LW-1:0]     cfg_data     = '0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [7:0]        first_red    = '0;
	logic [7:0]        first_green  = '0;
	logic [7:0]        first_blue   = '0;
	logic [7:0]        second_red   = '0;
	logic [7:0]        second_green = '0;
	logic [7:0]        second_blue  = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [7:0]        out_red;
	logic [7:0]        out_green;
	logic [7:0]        out_blue;
	logic [1:0]        region;
	logic              end_of_line;
	logic              end_of_frame;

	logic [vsbj_pkg::CFG_IDX_W-1:0] reg_ids [4] = '{vsbj_pkg::CFG_OUT_ROWS,
		vsbj_pkg::CFG_OUT_COLS, vsbj_pkg::CFG_FIRST_ROWS, vsbj_pkg::CFG_SECOND_ROWS};

	// joiner model state
	int unsigned lines_out   = vsbj_pkg::OUT_ROWS_RST;
	int unsigned cols_out    = vsbj_pkg::OUT_COLS_RST;
	int unsigned upper_lines = vsbj_pkg::FIRST_ROWS_RST;
	int unsigned lower_lines = vsbj_pkg::SECOND_ROWS_RST;
	int unsigned cur_row     = 0;
	int unsigned cur_col     = 0;

	joined_px_t  pending_px[$];
	int unsigned mismatches   = 0;
	int unsigned pixels_sent  = 0;
	int unsigned reg_writes   = 0;
	int unsigned rgn_seen [4] = '{0, 0, 0, 0};
	int unsigned hold_off_req = 0;
	bit          steady       = 1'b0;

	vertical_seam_blend_joiner DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.first_red    (first_red),
		.first_green  (first_green),
		.first_blue   (first_blue),
		.second_red   (second_red),
		.second_green (second_green),
		.second_blue  (second_blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_red      (out_red),
		.out_green    (out_green),
		.out_blue     (out_blue),
		.region       (region),
		.end_of_line  (end_of_line),
		.end_of_frame (end_of_frame)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic int unsigned clamp_lines(input int unsigned v);
		return (v > LINE_LIMIT) ? LINE_LIMIT : v;
	endfunction

	function automatic logic [vsbj_pkg::CH_W-1:0] feather(input logic [vsbj_pkg::CH_W-1:0] p1,
			input logic [vsbj_pkg::CH_W-1:0] p2, input int unsigned w);
		int unsigned acc;
		acc = p1 * (65536 - w) + p2 * w;
		return vsbj_pkg::CH_W'(acc >> 16);
	endfunction

	function automatic joined_px_t join_pixel(input vsbj_pkg::pix_t up,
			input vsbj_pkg::pix_t lo);
		int unsigned orow, frow, srow, y, lim, bend, wgt;
		logic        eol, eof;
		joined_px_t  px;
		orow = clamp_lines(lines_out);
		frow = clamp_lines(upper_lines);
		srow = clamp_lines(lower_lines);
		y    = (orow > srow) ? orow - srow : 0;
		lim  = (orow < frow) ? orow : frow;
		if (y + srow < lim)
			lim = y + srow;
		bend = (lim > y) ? lim : y;
		wgt  = 0;
		if (cur_row >= orow)
			px.rgn = vsbj_pkg::RGN_BLACK;
		else if (cur_row < y)
			px.rgn = vsbj_pkg::RGN_UPPER;
		else if (cur_row < bend) begin
			px.rgn = vsbj_pkg::RGN_BLEND;
			wgt    = (((cur_row - y) << 16) / (frow - y)) & 32'hFFFF;
		end else if (bend - y < srow)
			px.rgn = (cur_row < y + srow) ? vsbj_pkg::RGN_LOWER : vsbj_pkg::RGN_BLACK;
		else if (bend < frow)
			px.rgn = (cur_row < frow) ? vsbj_pkg::RGN_UPPER : vsbj_pkg::RGN_BLACK;
		else
			px.rgn = vsbj_pkg::RGN_BLACK;
		case (px.rgn)
			vsbj_pkg::RGN_UPPER: px.rgb = up;
			vsbj_pkg::RGN_LOWER: px.rgb = lo;
			vsbj_pkg::RGN_BLEND: begin
				for (int ch = 0; ch < 3; ch++)
					px.rgb[ch] = feather(up[ch], lo[ch], wgt);
			end
			default:   px.rgb = '0;
		endcase
		eol = (cur_col + 1 >= cols_out);
		eof = eol && (cur_row + 1 >= orow);
		if (eol) begin
			cur_col = 0;
			cur_row = eof ? 0 : ((cur_row + 1) & LINE_MASK);
		end else
			cur_col = (cur_col + 1) & LINE_MASK;
		px.eol = eol;
		px.eof = eof;
		return px;
	endfunction

	function automatic int unsigned pick_pause(input int unsigned pct);
		int unsigned r;
		if (steady || $urandom_range(0, 99) >= pct)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 94)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic vsbj_pkg::pix_t rand_pix();
		vsbj_pkg::pix_t p;
		case ($urandom_range(0, 7))
			0:       p = '0;
			1:       p = '1;
			default: p = vsbj_pkg::pix_t'($urandom);
		endcase
		return p;
	endfunction

	function automatic logic [LW-1:0] edge_lines();
		logic [LW-1:0] v;
		case ($urandom_range(0, 3))
			0:       v = '0;
			1:       v = 1;
			2:       v = LW'(LINE_LIMIT - 1);
			default: v = '1;
		endcase
		return v;
	endfunction

	task automatic write_reg(input logic [vsbj_pkg::CFG_IDX_W-1:0] idx,
			input logic [LW-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			vsbj_pkg::CFG_OUT_ROWS:    lines_out   = val;
			vsbj_pkg::CFG_OUT_COLS:    cols_out    = val;
			vsbj_pkg::CFG_FIRST_ROWS:  upper_lines = val;
			vsbj_pkg::CFG_SECOND_ROWS: lower_lines = val;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_frame(input logic [LW-1:0] rows, input logic [LW-1:0] cols,
			input logic [LW-1:0] upper, input logic [LW-1:0] lower);
		write_reg(vsbj_pkg::CFG_OUT_ROWS, rows);
		write_reg(vsbj_pkg::CFG_OUT_COLS, cols);
		write_reg(vsbj_pkg::CFG_FIRST_ROWS, upper);
		write_reg(vsbj_pkg::CFG_SECOND_ROWS, lower);
	endtask

	task automatic send_pixel(input vsbj_pkg::pix_t up, input vsbj_pkg::pix_t lo);
		int unsigned gap;
		in_valid     <= 1'b1;
		first_red    <= up[vsbj_pkg::CH_RED];
		first_green  <= up[vsbj_pkg::CH_GREEN];
		first_blue   <= up[vsbj_pkg::CH_BLUE];
		second_red   <= lo[vsbj_pkg::CH_RED];
		second_green <= lo[vsbj_pkg::CH_GREEN];
		second_blue  <= lo[vsbj_pkg::CH_BLUE];
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		pending_px = {pending_px, join_pixel(up, lo)};
		pixels_sent++;
		gap = pick_pause(30);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic stop_sending();
		in_valid <= 1'b0;
	endtask

	task automatic await_idle();
		while (pending_px.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_burst(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			send_pixel(rand_pix(), rand_pix());
		stop_sending();
		await_idle();
	endtask

	task automatic test_default_setting();
		send_pixel('0, '1);
		send_pixel('1, '0);
		stop_sending();
		await_idle();
	endtask

	task automatic test_zero_sizes();
		set_frame(0, 0, 0, 0);
		send_burst(2);
	endtask

	task automatic test_feather_rows();
		set_frame(6, 1, 4, 4);
		for (int i = 0; i < 6; i++)
			send_pixel('1, '0);
		stop_sending();
		await_idle();
	endtask

	task automatic test_short_upper();
		set_frame(6, 1, 1, 3);
		send_burst(6);
	endtask

	task automatic test_shrink_mid_frame();
		set_frame(8, 1, 8, 8);
		send_burst(4);
		write_reg(vsbj_pkg::CFG_OUT_ROWS, 2);
		send_burst(1);
		write_reg(vsbj_pkg::CFG_OUT_COLS, 4);
		send_burst(2);
		write_reg(vsbj_pkg::CFG_OUT_COLS, 1);
		send_burst(1);
	endtask

	task automatic test_extremes();
		set_frame('1, '1, '1, '1);
		send_burst(2);
		set_frame('1, 1, 0, 0);
		send_burst(2);
	endtask

	task automatic test_output_stall();
		set_frame(5, 3, 4, 3);
		steady       = 1'b1;
		hold_off_req = HOLD_CYCLES;
		for (int i = 0; i < 40; i++)
			send_pixel(rand_pix(), rand_pix());
		stop_sending();
		steady = 1'b0;
		await_idle();
	endtask

	task automatic test_random_frames();
		int unsigned kind, frame, n;
		while (pixels_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0: set_frame(LW'($urandom_range(64, 400)), 1, LW'($urandom_range(0, 420)),
					LW'($urandom_range(0, 420)));
				1: set_frame(edge_lines(), edge_lines(), edge_lines(), edge_lines());
				2: write_reg(reg_ids[$urandom_range(0, 3)], LW'($urandom_range(0, 15)));
				default: set_frame(LW'($urandom_range(0, 12)), LW'($urandom_range(0, 6)),
					LW'($urandom_range(0, 14)), LW'($urandom_range(0, 14)));
			endcase
			frame = ((lines_out == 0) ? 1 : lines_out) * ((cols_out == 0) ? 1 : cols_out);
			n     = (frame > 150) ? 150 : frame * $urandom_range(1, 3);
			if (n > 150)
				n = 150;
			if ($urandom_range(0, 9) < 3 || (kind == 1 && n > 40))
				n = $urandom_range(1, (n > 40 && kind == 1) ? 40 : n);
			steady = ($urandom_range(0, 4) == 0);
			for (int unsigned i = 0; i < n; i++)
				send_pixel(rand_pix(), rand_pix());
			stop_sending();
			steady = 1'b0;
			await_idle();
		end
	endtask

	task automatic check_field(input string label, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, label, want, got);
			mismatches++;
		end
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin : result_drain
		int unsigned wait_left;
		wait_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req != 0) begin
				wait_left    = hold_off_req;
				hold_off_req = 0;
			end else if (wait_left == 0)
				wait_left = pick_pause(25);
			if (wait_left != 0) begin
				out_ready <= 1'b0;
				wait_left--;
			end else
				out_ready <= 1'b1;
		end
	end

	initial begin : result_check
		joined_px_t want;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (pending_px.size() == 0) begin
					$display("%0t: transaction with no pixel pending", $time);
					mismatches++;
				end else begin
					want = pending_px.pop_front();
					check_field("out_red", want.rgb[vsbj_pkg::CH_RED], out_red);
					check_field("out_green", want.rgb[vsbj_pkg::CH_GREEN], out_green);
					check_field("out_blue", want.rgb[vsbj_pkg::CH_BLUE], out_blue);
					check_field("region", want.rgn, region);
					check_field("end_of_line", want.eol, end_of_line);
					check_field("end_of_frame", want.eof, end_of_frame);
					rgn_seen[region]++;
				end
			end
		end
	end

	initial begin : run_limit
		#(CLK_PERIOD * 3_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin : test_sequence
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_setting();
		test_zero_sizes();
		test_feather_rows();
		test_short_upper();
		test_shrink_mid_frame();
		test_extremes();
		test_output_stall();
		test_random_frames();
		$display("Joined %0d pixels over %0d register writes, with a %0d-cycle output stall",
			pixels_sent, reg_writes, HOLD_CYCLES);
		$display("Regions: upper %0d, blend %0d, lower %0d, black %0d",
			rgn_seen[vsbj_pkg::RGN_UPPER], rgn_seen[vsbj_pkg::RGN_BLEND],
			rgn_seen[vsbj_pkg::RGN_LOWER], rgn_seen[vsbj_pkg::RGN_BLACK]);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
design/vsbj_pkg.sv
design/vsbj_front.sv
design/vsbj_queue.sv
design/vsbj_div.sv
design/vsbj_back.sv
design/vertical_seam_blend_joiner.sv
design/vsbj_checker.sv
verif/vertical_seam_blend_joiner_test.sv
